FILE: hdl/lj_pair_force_accumulator_core_assert.svh
// Assertion macros shared by the pair force accumulator.
`ifndef LJ_PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH
`define LJ_PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LJPFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ljpfa assertion failed");

// Next-cycle implication, disabled during reset.
`define LJPFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ljpfa assertion failed");

`endif

FILE: hdl/ljpfa_pkg.sv
// Types, constants and helper functions of the pair force accumulator.
package ljpfa_pkg;

  localparam int DEF_MAX_ATOMS = 1024;
  localparam int TAGW          = 8;
  localparam int PAW           = 5;

  localparam logic [63:0] ONE_Q24 = 64'h0000_0000_0100_0000;
  localparam logic [63:0] SIX_Q24 = 64'h0000_0000_0600_0000;
  localparam logic [61:0] CAP     = 62'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] S_MAX48 = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] S_MIN48 = -S_MAX48 - 65'sd1;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_PAIR  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  localparam logic [2:0] REG_WELL   = 3'd0;
  localparam logic [2:0] REG_SIGMA  = 3'd1;
  localparam logic [2:0] REG_CUTOFF = 3'd2;
  localparam logic [2:0] REG_SHIFT  = 3'd3;
  localparam logic [2:0] REG_ATOMS  = 3'd4;

  // Multiply sequence of one pair.
  localparam logic [3:0] MS_SR4  = 4'd0;
  localparam logic [3:0] MS_A    = 4'd1;
  localparam logic [3:0] MS_B    = 4'd2;
  localparam logic [3:0] MS_EN   = 4'd3;
  localparam logic [3:0] MS_B6   = 4'd4;
  localparam logic [3:0] MS_T    = 4'd5;
  localparam logic [3:0] MS_FMAG = 4'd6;
  localparam logic [3:0] MS_FX   = 4'd7;
  localparam logic [3:0] MS_FY   = 4'd8;
  localparam logic [3:0] MS_FZ   = 4'd9;

  typedef struct packed {
    logic [31:0]        well;
    logic [31:0]        sigma;
    logic [31:0]        cutoff;
    logic signed [31:0] shift;
    logic [10:0]        atoms;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       new_frame;
    logic       div_start;
    logic       div_inv;
    logic       mul_start;
    logic [3:0] mul_step;
    logic       rd;
    logic       cap_i;
    logic       cap_j;
    logic       wr;
    logic       sel_j;
    logic       clr;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    act_t action;
    logic skip;
    logic div_done;
    logic mul_done;
    logic epoch_max;
  } sts_t;

  // Saturating add into a 48 bit accumulator; top bit flags saturation.
  function automatic logic [48:0] sat_add48(input logic signed [47:0] acc,
                                            input logic signed [63:0] delta);
    logic signed [64:0] s;
    s = 65'(acc) + 65'(delta);
    if (s > S_MAX48) return {1'b1, 48'h7FFF_FFFF_FFFF};
    else if (s < S_MIN48) return {1'b1, 48'h8000_0000_0000};
    else return {1'b0, s[47:0]};
  endfunction

endpackage

FILE: hdl/ljpfa_if.sv
// Item channel interfaces of the pair force accumulator.
interface ljpfa_in_if;
  import ljpfa_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  first_atom;
  logic [9:0]  second_atom;
  logic signed [31:0] delta_x;
  logic signed [31:0] delta_y;
  logic signed [31:0] delta_z;
  logic [31:0] distance_squared;
  modport source(output valid, action, first_atom, second_atom, delta_x, delta_y,
                 delta_z, distance_squared, input ready);
  modport sink(input valid, action, first_atom, second_atom, delta_x, delta_y,
               delta_z, distance_squared, output ready);
endinterface

interface ljpfa_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic signed [47:0] total_energy;
  logic        pair_ignored;
  modport source(output valid, force_x, force_y, force_z, total_energy, pair_ignored,
                 input ready);
  modport sink(input valid, force_x, force_y, force_z, total_energy, pair_ignored,
               output ready);
endinterface

FILE: hdl/lj_pair_force_accumulator_core.sv
// Top level of the Lennard-Jones pair force accumulator.
//
//   channel   direction  handshake          contents
//   in_ch     in         valid/ready        action, atoms, displacement, r squared
//   out_ch    out        valid/ready        forces, energy total, ignored flag
//   apb       in         psel/penable       five configuration registers
//
// A pair item passes through decode, two divisions, ten products, the reads of its
// two force entries and the writes of both, then result and idle. Frame, read and
// filtered pair items go from decode straight to result.
// After reset, and after every 255th frame item, a clearing pass runs through the
// force store while no item is accepted.
// A new item is taken while the previous result still waits in the output register.
`include "lj_pair_force_accumulator_core_assert.svh"
module lj_pair_force_accumulator_core import ljpfa_pkg::*; #(
  parameter int MAX_ATOMS = DEF_MAX_ATOMS
) (
  input  logic            clk,
  input  logic            rst_n,
  ljpfa_in_if.sink        in_ch,
  ljpfa_out_if.source     out_ch,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [PAW-1:0]  paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  localparam int AW = $clog2(MAX_ATOMS);

  cfg_t          cfg_r;
  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] clr_addr;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PAW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.well   <= 32'h0001_0000;
      cfg_r.sigma  <= 32'h0001_0000;
      cfg_r.cutoff <= '0;
      cfg_r.shift  <= '0;
      cfg_r.atoms  <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WELL:   cfg_r.well   <= pwdata;
        REG_SIGMA:  cfg_r.sigma  <= pwdata;
        REG_CUTOFF: cfg_r.cutoff <= pwdata;
        REG_SHIFT:  cfg_r.shift  <= pwdata;
        REG_ATOMS:  cfg_r.atoms  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WELL:   prdata = cfg_r.well;
      REG_SIGMA:  prdata = cfg_r.sigma;
      REG_CUTOFF: prdata = cfg_r.cutoff;
      REG_SHIFT:  prdata = cfg_r.shift;
      REG_ATOMS:  prdata = 32'(cfg_r.atoms);
      default:    prdata = '0;
    endcase
  end

  ljpfa_ctrl #(.MAX_ATOMS(MAX_ATOMS), .AW(AW)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd), .clr_addr(clr_addr)
  );

  ljpfa_dpath #(.MAX_ATOMS(MAX_ATOMS), .AW(AW)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_action(in_ch.action), .in_first_atom(in_ch.first_atom),
    .in_second_atom(in_ch.second_atom), .in_delta_x(in_ch.delta_x),
    .in_delta_y(in_ch.delta_y), .in_delta_z(in_ch.delta_z),
    .in_distance_squared(in_ch.distance_squared),
    .cmd(cmd), .clr_addr(clr_addr), .sts(sts),
    .out_force_x(out_ch.force_x), .out_force_y(out_ch.force_y),
    .out_force_z(out_ch.force_z), .out_total_energy(out_ch.total_energy),
    .out_pair_ignored(out_ch.pair_ignored)
  );

  // One item at a time: the block is busy in the cycle after an accept.
  `LJPFA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // No item is taken while the clearing pass runs.
  `LJPFA_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, cmd.clr, !in_ch.ready)
  // A result is only loaded when the output register is free or being drained.
  `LJPFA_ASSERT_IMP(a_out_free_on_load, clk, rst_n, cmd.out_load, !out_ch.valid || out_ch.ready)
endmodule

FILE: hdl/ljpfa_div.sv
// Restoring divider, one quotient bit per cycle, 56 bit dividend by 32 bit divisor.
module ljpfa_div import ljpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [55:0] dividend,
  input  logic [31:0] divisor,
  output logic [55:0] quotient,
  output logic        done
);
  logic [55:0] quo_r;
  logic [31:0] rem_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] rem_sh, rem_sub;
  logic        qbit;

  assign rem_sh  = {rem_r, quo_r[55]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign qbit    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd55) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[54:0], qbit};
      rem_r <= qbit ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

FILE: hdl/ljpfa_mul.sv
// Q40.24 multiplier over four 32x32 partial products, saturating at 2^62-1.
module ljpfa_mul import ljpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic [61:0] res,
  output logic        done
);
  logic [63:0]  x_r, y_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         busy_r, done_r;
  logic [31:0]  xa, yb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign xa = cnt_r[1] ? x_r[63:32] : x_r[31:0];
  assign yb = cnt_r[0] ? y_r[63:32] : y_r[31:0];
  assign pp = 64'(xa) * 64'(yb);

  always_comb begin
    case ({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]})
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      2'd2:    pp_sh = {pp, 64'b0};
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign res  = (|acc_r[127:86]) ? CAP : acc_r[85:24];
  assign done = done_r;
endmodule

FILE: hdl/ljpfa_dpath.sv
// Datapath: item registers, divider, multiplier, force store and result register.
module ljpfa_dpath import ljpfa_pkg::*; #(
  parameter int MAX_ATOMS = DEF_MAX_ATOMS,
  parameter int AW        = $clog2(MAX_ATOMS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic [1:0]        in_action,
  input  logic [9:0]        in_first_atom,
  input  logic [9:0]        in_second_atom,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  input  logic signed [31:0] in_delta_z,
  input  logic [31:0]       in_distance_squared,
  input  cmd_t              cmd,
  input  logic [AW-1:0]     clr_addr,
  output sts_t              sts,
  output logic signed [47:0] out_force_x,
  output logic signed [47:0] out_force_y,
  output logic signed [47:0] out_force_z,
  output logic signed [47:0] out_total_energy,
  output logic              out_pair_ignored
);
  localparam int EW = 144 + TAGW;

  logic [1:0]  act_r;
  logic [9:0]  i_r, j_r;
  logic [31:0] d_r [3];
  logic [31:0] r2_r;
  logic        flag_r, rd_ok_r;
  logic [55:0] sr2_r, invr2_r;
  logic [61:0] p_r, a_r, b_r, t_r, fmag_r;
  logic [61:0] fm_r [3];
  logic [3:0]  mstep_r;
  logic        dinv_r;
  logic signed [47:0] energy_r;
  logic [TAGW-1:0] epoch_r;
  logic [EW-1:0] mem [MAX_ATOMS];
  logic [EW-1:0] mem_q, qi_r, qj_r;

  // Pair filter on the incoming item.
  logic skip_in;
  logic [16:0] fi_ext, si_ext, ie, je;
  assign fi_ext = 17'(in_first_atom);
  assign si_ext = 17'(in_second_atom);
  assign skip_in = (cfg.atoms < 11'd2) || (cfg.cutoff == 32'd0) ||
                   (in_distance_squared == 32'd0) || (in_distance_squared > cfg.cutoff) ||
                   ({1'b0, in_first_atom} >= cfg.atoms) ||
                   ({1'b0, in_second_atom} >= cfg.atoms) ||
                   (fi_ext >= 17'(MAX_ATOMS)) || (si_ext >= 17'(MAX_ATOMS)) ||
                   (in_first_atom == in_second_atom);
  assign ie = 17'(i_r);
  assign je = 17'(j_r);

  // Divider and multiplier.
  logic [55:0] div_q;
  logic        div_done, mul_done;
  logic [61:0] mul_res;
  logic [63:0] mx, my;
  logic [63:0] a64, abs_am1, two_a, abs_2am1;
  logic        a_ge1, fneg;
  logic [31:0] dmag [3];

  assign a64      = {2'b0, a_r};
  assign a_ge1    = a64 >= ONE_Q24;
  assign abs_am1  = a_ge1 ? a64 - ONE_Q24 : ONE_Q24 - a64;
  assign two_a    = {1'b0, a_r, 1'b0};
  assign fneg     = two_a < ONE_Q24;
  assign abs_2am1 = fneg ? ONE_Q24 - two_a : two_a - ONE_Q24;

  always_comb begin
    for (int k = 0; k < 3; k++) dmag[k] = d_r[k][31] ? 32'd0 - d_r[k] : d_r[k];
  end

  ljpfa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(cmd.div_inv ? 56'h00_0100_0000_0000 : {cfg.sigma, 24'b0}),
    .divisor(r2_r), .quotient(div_q), .done(div_done)
  );

  always_comb begin
    case (cmd.mul_step)
      MS_SR4:  begin mx = {8'b0, sr2_r};        my = {8'b0, sr2_r}; end
      MS_A:    begin mx = {2'b0, p_r};          my = {8'b0, sr2_r}; end
      MS_B:    begin mx = {22'b0, cfg.well, 10'b0}; my = a64;       end
      MS_EN:   begin mx = {2'b0, b_r};          my = abs_am1;       end
      MS_B6:   begin mx = {2'b0, b_r};          my = SIX_Q24;       end
      MS_T:    begin mx = {2'b0, p_r};          my = {8'b0, invr2_r}; end
      MS_FMAG: begin mx = {2'b0, t_r};          my = abs_2am1;      end
      MS_FX:   begin mx = {2'b0, fmag_r};       my = {24'b0, dmag[0], 8'b0}; end
      MS_FY:   begin mx = {2'b0, fmag_r};       my = {24'b0, dmag[1], 8'b0}; end
      MS_FZ:   begin mx = {2'b0, fmag_r};       my = {24'b0, dmag[2], 8'b0}; end
      default: begin mx = '0;                   my = '0;            end
    endcase
  end

  ljpfa_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .x(mx), .y(my),
    .res(mul_res), .done(mul_done)
  );

  // Energy term: signed magnitude minus the per-pair shift.
  logic signed [63:0] em_s, term;
  logic [48:0] en_sum;
  assign em_s   = {2'b0, mul_res};
  assign term   = (a_ge1 ? em_s : -em_s) - {{24{cfg.shift[31]}}, cfg.shift, 8'b0};
  assign en_sum = sat_add48(energy_r, term);

  // Force update of one entry; a stale entry counts as zero.
  logic [EW-1:0] base, wd;
  logic [47:0]   bval [3];
  logic [48:0]   fsum [3];
  logic          wsat;
  logic signed [63:0] fdelta [3];
  logic [AW-1:0] addr;

  always_comb begin
    base = cmd.sel_j ? qj_r : qi_r;
    wsat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      bval[k]   = (base[EW-1 -: TAGW] == epoch_r) ? base[48*k +: 48] : 48'd0;
      fdelta[k] = (fneg ^ d_r[k][31] ^ cmd.sel_j) ? -{2'b0, fm_r[k]} : {2'b0, fm_r[k]};
      fsum[k]   = sat_add48(bval[k], fdelta[k]);
      wsat      = wsat | fsum[k][48];
    end
    wd = {epoch_r, fsum[2][47:0], fsum[1][47:0], fsum[0][47:0]};
    if (cmd.clr) addr = clr_addr;
    else if (cmd.sel_j) addr = je[AW-1:0];
    else addr = ie[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) mem[addr] <= '0;
    else if (cmd.wr) mem[addr] <= wd;
    if (cmd.rd) mem_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      epoch_r  <= TAGW'(1);
    end else begin
      if (cmd.new_frame) begin
        energy_r <= '0;
        // The tag counter skips zero, which the clearing pass writes.
        epoch_r  <= (&epoch_r) ? TAGW'(1) : epoch_r + TAGW'(1);
      end else if (mul_done && mstep_r == MS_EN) begin
        energy_r <= en_sum[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      i_r     <= in_first_atom;
      j_r     <= in_second_atom;
      d_r[0]  <= in_delta_x;
      d_r[1]  <= in_delta_y;
      d_r[2]  <= in_delta_z;
      r2_r    <= in_distance_squared;
      flag_r  <= (in_action == ACT_PAIR) && skip_in;
      rd_ok_r <= fi_ext < 17'(MAX_ATOMS);
    end else begin
      if (mul_done && mstep_r == MS_EN && en_sum[48]) flag_r <= 1'b1;
      if (cmd.wr && wsat) flag_r <= 1'b1;
    end
    if (cmd.div_start) dinv_r <= cmd.div_inv;
    if (div_done) begin
      if (dinv_r) invr2_r <= div_q;
      else sr2_r <= div_q;
    end
    if (cmd.mul_start) mstep_r <= cmd.mul_step;
    if (mul_done) begin
      case (mstep_r)
        MS_SR4:  p_r     <= mul_res;
        MS_A:    a_r     <= mul_res;
        MS_B:    b_r     <= mul_res;
        MS_B6:   p_r     <= mul_res;
        MS_T:    t_r     <= mul_res;
        MS_FMAG: fmag_r  <= mul_res;
        MS_FX:   fm_r[0] <= mul_res;
        MS_FY:   fm_r[1] <= mul_res;
        MS_FZ:   fm_r[2] <= mul_res;
        default: ;
      endcase
    end
    if (cmd.cap_i) qi_r <= mem_q;
    if (cmd.cap_j) qj_r <= mem_q;
  end

  // Result register.
  logic rd_hit;
  assign rd_hit = (act_r == ACT_READ) && rd_ok_r && (mem_q[EW-1 -: TAGW] == epoch_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_force_x      <= rd_hit ? mem_q[47:0]   : 48'd0;
      out_force_y      <= rd_hit ? mem_q[95:48]  : 48'd0;
      out_force_z      <= rd_hit ? mem_q[143:96] : 48'd0;
      out_total_energy <= energy_r;
      out_pair_ignored <= flag_r;
    end
  end

  assign sts.action    = act_t'(act_r);
  assign sts.skip      = flag_r;
  assign sts.div_done  = div_done;
  assign sts.mul_done  = mul_done;
  assign sts.epoch_max = &epoch_r;
endmodule

FILE: hdl/ljpfa_ctrl.sv
// Controller: sequences each item through the datapath and runs the clearing pass.
module ljpfa_ctrl import ljpfa_pkg::*; #(
  parameter int MAX_ATOMS = DEF_MAX_ATOMS,
  parameter int AW        = $clog2(MAX_ATOMS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [AW-1:0] clr_addr
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_CLEAR  = 11'b000_0000_0010,
    S_DECODE = 11'b000_0000_0100,
    S_DIV1   = 11'b000_0000_1000,
    S_DIV2   = 11'b000_0001_0000,
    S_MUL    = 11'b000_0010_0000,
    S_RDJ    = 11'b000_0100_0000,
    S_WRI    = 11'b000_1000_0000,
    S_WRJ    = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_MGO    = 11'b100_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          clr_pend_r, clr_pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    step_nxt      = step_r;
    clr_pend_nxt  = clr_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_CLEAR: begin
        cmd.clr     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MAX_ATOMS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_DECODE: begin
        case (sts.action)
          ACT_FRAME: begin
            cmd.new_frame = 1'b1;
            clr_pend_nxt  = sts.epoch_max;
            state_nxt     = S_DONE;
          end
          ACT_PAIR: begin
            if (sts.skip) state_nxt = S_DONE;
            else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV1;
            end
          end
          ACT_READ: begin
            cmd.rd    = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_inv   = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_step  = MS_SR4;
          step_nxt      = MS_SR4;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = step_r;
        if (sts.mul_done) begin
          if (step_r == MS_FZ) begin
            cmd.rd    = 1'b1;
            state_nxt = S_RDJ;
          end else begin
            step_nxt  = step_r + 4'd1;
            state_nxt = S_MGO;
          end
        end
      end
      S_MGO: begin
        // The product just finished is in its register now, so the next one may start.
        cmd.mul_start = 1'b1;
        cmd.mul_step  = step_r;
        state_nxt     = S_MUL;
      end
      S_RDJ: begin
        cmd.rd    = 1'b1;
        cmd.sel_j = 1'b1;
        cmd.cap_i = 1'b1;
        state_nxt = S_WRI;
      end
      S_WRI: begin
        cmd.wr    = 1'b1;
        cmd.cap_j = 1'b1;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        cmd.wr    = 1'b1;
        cmd.sel_j = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          clr_pend_nxt  = 1'b0;
          state_nxt     = clr_pend_r ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      step_r      <= step_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign clr_addr  = clr_cnt_r;
endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the Lennard-Jones pair force accumulator.
module testbench;
  import ljpfa_pkg::*;

  localparam logic [63:0] MAG_CAP  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] UNIT_Q24 = 64'h0000_0000_0100_0000;
  localparam logic signed [64:0] ACC_HI = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] ACC_LO = -ACC_HI - 65'sd1;
  localparam int NUM_SLOTS   = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 3000;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  first_atom;
    logic [9:0]  second_atom;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
    logic [31:0] delta_z;
    logic [31:0] distance_squared;
  } pair_item_t;

  typedef struct packed {
    logic [47:0] force_x;
    logic [47:0] force_y;
    logic [47:0] force_z;
    logic [47:0] total_energy;
    logic        pair_ignored;
  } lj_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ljpfa_in_if  in_ch();
  ljpfa_out_if out_ch();

  lj_pair_force_accumulator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0]        m_well = 32'd65536, m_sigma = 32'd65536, m_cutoff = '0;
  logic signed [31:0] m_shift = '0;
  logic [10:0]        m_atoms = '0;
  logic signed [47:0] m_force [NUM_SLOTS][3];
  bit                 m_epoch_of [NUM_SLOTS];
  bit                 m_epoch = 1'b0;
  logic signed [47:0] m_energy = '0;

  lj_result_t expected_results[$];
  int errors = 0;
  int burst_left = 0;
  int hold_req = 0, hold_ack = 0, hold_left = 0;
  int rx_tick = 0;
  int cycles = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [63:0] mul_q24(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    if (p[127:86] != '0) return MAG_CAP;
    return p[87:24];
  endfunction

  function automatic logic signed [47:0] clamp_add(input logic signed [47:0] acc,
                                                   input logic signed [63:0] d,
                                                   inout bit sat);
    logic signed [64:0] s;
    s = 65'(acc) + 65'(d);
    if (s > ACC_HI) begin
      sat = 1'b1;
      return ACC_HI[47:0];
    end
    if (s < ACC_LO) begin
      sat = 1'b1;
      return ACC_LO[47:0];
    end
    return s[47:0];
  endfunction

  function automatic void refresh_slot(input int idx);
    if (m_epoch_of[idx] != m_epoch) begin
      for (int k = 0; k < 3; k++) m_force[idx][k] = '0;
      m_epoch_of[idx] = m_epoch;
    end
  endfunction

  function automatic bit accumulate_pair(input pair_item_t it);
    logic [63:0] r2, sr2, inv_r2, a, b, t, two_a, fmag, dmag;
    logic signed [63:0] term, d, f;
    logic [31:0] dv [3];
    bit sat, fneg, dneg;
    int i, j;
    sat = 1'b0;
    i = it.first_atom;
    j = it.second_atom;
    r2 = {32'd0, it.distance_squared};
    if (m_atoms < 2 || m_cutoff == 0 || r2 == 0 || r2 > {32'd0, m_cutoff}) return 1'b1;
    if (i >= m_atoms || j >= m_atoms || i == j) return 1'b1;
    sr2 = ({32'd0, m_sigma} << 24) / r2;
    inv_r2 = (64'd1 << 40) / r2;
    a = mul_q24(mul_q24(sr2, sr2), sr2);
    b = mul_q24({22'd0, m_well, 10'd0}, a);
    if (a >= UNIT_Q24) term = $signed(mul_q24(b, a - UNIT_Q24));
    else term = -$signed(mul_q24(b, UNIT_Q24 - a));
    term = term - 64'(m_shift) * 64'sd256;
    m_energy = clamp_add(m_energy, term, sat);
    t = mul_q24(mul_q24(b, 64'd6 << 24), inv_r2);
    two_a = a << 1;
    fneg = two_a < UNIT_Q24;
    fmag = mul_q24(t, fneg ? UNIT_Q24 - two_a : two_a - UNIT_Q24);
    refresh_slot(i);
    refresh_slot(j);
    dv[0] = it.delta_x;
    dv[1] = it.delta_y;
    dv[2] = it.delta_z;
    for (int k = 0; k < 3; k++) begin
      d = 64'($signed(dv[k]));
      dneg = d < 0;
      dmag = dneg ? 64'(-d) : 64'(d);
      f = $signed(mul_q24(fmag, dmag << 8));
      if (fneg != dneg) f = -f;
      m_force[i][k] = clamp_add(m_force[i][k], f, sat);
      m_force[j][k] = clamp_add(m_force[j][k], -f, sat);
    end
    return sat;
  endfunction

  function automatic lj_result_t predict_result(input pair_item_t it);
    lj_result_t r;
    r = '0;
    case (act_t'(it.action))
      ACT_FRAME: begin
        m_epoch ^= 1'b1;
        for (int n = 0; n < NUM_SLOTS; n++) m_epoch_of[n] = ~m_epoch;
        m_energy = '0;
      end
      ACT_PAIR: r.pair_ignored = accumulate_pair(it);
      ACT_READ: begin
        if (m_epoch_of[it.first_atom] == m_epoch) begin
          r.force_x = m_force[it.first_atom][0];
          r.force_y = m_force[it.first_atom][1];
          r.force_z = m_force[it.first_atom][2];
        end
      end
      default: ;
    endcase
    r.total_energy = m_energy;
    return r;
  endfunction

  task automatic send_item(input pair_item_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.action <= it.action;
    in_ch.first_atom <= it.first_atom;
    in_ch.second_atom <= it.second_atom;
    in_ch.delta_x <= it.delta_x;
    in_ch.delta_y <= it.delta_y;
    in_ch.delta_z <= it.delta_z;
    in_ch.distance_squared <= it.distance_squared;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_result(it));
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WELL:   m_well = value;
      REG_SIGMA:  m_sigma = value;
      REG_CUTOFF: m_cutoff = value;
      REG_SHIFT:  m_shift = value;
      REG_ATOMS:  m_atoms = value[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_physics(input logic [31:0] well, input logic [31:0] sigma,
                             input logic [31:0] cutoff, input logic [31:0] shift,
                             input logic [31:0] atoms);
    write_reg(REG_WELL, well);
    write_reg(REG_SIGMA, sigma);
    write_reg(REG_CUTOFF, cutoff);
    write_reg(REG_SHIFT, shift);
    write_reg(REG_ATOMS, atoms);
  endtask

  function automatic pair_item_t make_item(input act_t act, input int i, input int j,
                                           input logic [31:0] dx, input logic [31:0] dy,
                                           input logic [31:0] dz, input logic [31:0] r2);
    pair_item_t it;
    it.action = act;
    it.first_atom = i[9:0];
    it.second_atom = j[9:0];
    it.delta_x = dx;
    it.delta_y = dy;
    it.delta_z = dz;
    it.distance_squared = r2;
    return it;
  endfunction

  // A physically sensible pair: distance around sigma, small displacements.
  function automatic pair_item_t plausible_pair(input int atoms);
    int i, j;
    i = $urandom_range(0, atoms - 1);
    j = $urandom_range(0, atoms - 1);
    return make_item(ACT_PAIR, i, j, $urandom_range(0, 327680) - 163840,
                     $urandom_range(0, 327680) - 163840, $urandom_range(0, 327680) - 163840,
                     $urandom_range(52000, 420000));
  endfunction

  task automatic test_directed();
    set_physics(32'd65536, 32'd65536, 32'd409600, 32'd4096, 32'd8);
    send_item(make_item(ACT_FRAME, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, 3, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_PAIR, 0, 1, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000));
    send_item(make_item(ACT_PAIR, 1, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'd409600));
    send_item(make_item(ACT_PAIR, 2, 3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd1));
    // Zero distance, distance beyond the cutoff, self pair and bad index.
    send_item(make_item(ACT_PAIR, 0, 1, 32'h100, 32'h100, 32'h100, 32'd0));
    send_item(make_item(ACT_PAIR, 0, 1, 32'h100, 32'h100, 32'h100, 32'd409601));
    send_item(make_item(ACT_PAIR, 4, 4, 32'h100, 32'h100, 32'h100, 32'd65536));
    send_item(make_item(ACT_PAIR, 8, 1, 32'h100, 32'h100, 32'h100, 32'd65536));
    send_item(make_item(ACT_PAIR, 1, 1023, 32'h100, 32'h100, 32'h100, 32'd65536));
    send_item(make_item(ACT_PAIR, 5, 6, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'd262144));
    send_item(make_item(ACT_NONE, 1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
    for (int n = 0; n < 8; n++) send_item(make_item(ACT_READ, n, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, 1023, 0, 0, 0, 0, 0));
    // After a new frame every entry is stale.
    send_item(make_item(ACT_FRAME, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, 1, 0, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_register_extremes();
    logic [31:0] settings [6][5];
    settings = '{
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1024},
      '{32'd0,         32'd0,         32'hFFFF_FFFF, 32'h8000_0000, 32'd1024},
      '{32'd65536,     32'd65536,     32'd0,         32'd0,         32'd16},
      '{32'd65536,     32'd65536,     32'd409600,    32'd0,         32'd1},
      '{32'd65536,     32'd65536,     32'd409600,    32'd0,         32'd0},
      '{32'd200000,    32'd80000,     32'd300000,    32'hFFFF_F000, 32'd2}
    };
    foreach (settings[s]) begin
      set_physics(settings[s][0], settings[s][1], settings[s][2], settings[s][3],
                  settings[s][4]);
      send_item(make_item(ACT_FRAME, 0, 0, 0, 0, 0, 0));
      for (int n = 0; n < 6; n++)
        send_item(make_item(ACT_PAIR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom, $urandom, $urandom, $urandom));
      send_item(make_item(ACT_PAIR, 0, 1, $urandom, $urandom, $urandom,
                          $urandom_range(1, 65536)));
      send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_READ, 1, 0, 0, 0, 0, 0));
      drain();
    end
  endtask

  task automatic test_random_frames();
    pair_item_t it;
    int atoms;
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      atoms = (phase == 4) ? 1024 : $urandom_range(2, 24);
      set_physics($urandom_range(30000, 200000), $urandom_range(40000, 120000),
                  $urandom_range(200000, 500000), $urandom_range(0, 8192) - 4096, atoms);
      send_item(make_item(ACT_FRAME, 0, 0, 0, 0, 0, 0));
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) it = plausible_pair(atoms);
        else if (pick < 83) it = make_item(ACT_READ, $urandom_range(0, atoms - 1), 0, 0, 0, 0, 0);
        else if (pick < 86) it = make_item(ACT_FRAME, $urandom, $urandom, 0, 0, 0, 0);
        else if (pick < 88) it = make_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom);
        else it = make_item(pick[0] ? ACT_PAIR : ACT_READ, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
        send_item(it);
      end
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    set_physics(32'd65536, 32'd65536, 32'd409600, 32'd0, 32'd8);
    hold_req++;
    for (int n = 0; n < 24; n++) begin
      burst_left = 2;
      send_item(n % 3 == 2 ? make_item(ACT_READ, $urandom_range(0, 7), 0, 0, 0, 0, 0)
                           : plausible_pair(8));
    end
    drain();
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    lj_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.force_x !== exp_r.force_x)
            report($sformatf("force_x %h, expected %h", out_ch.force_x, exp_r.force_x));
          if (out_ch.force_y !== exp_r.force_y)
            report($sformatf("force_y %h, expected %h", out_ch.force_y, exp_r.force_y));
          if (out_ch.force_z !== exp_r.force_z)
            report($sformatf("force_z %h, expected %h", out_ch.force_z, exp_r.force_z));
          if (out_ch.total_energy !== exp_r.total_energy)
            report($sformatf("total_energy %h, expected %h", out_ch.total_energy,
                             exp_r.total_energy));
          if (out_ch.pair_ignored !== exp_r.pair_ignored)
            report($sformatf("pair_ignored %b, expected %b", out_ch.pair_ignored,
                             exp_r.pair_ignored));
        end
      end
      rx_tick <= rx_tick + 1;
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_tick[7]) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.first_atom = '0;
    in_ch.second_atom = '0;
    in_ch.delta_x = '0;
    in_ch.delta_y = '0;
    in_ch.delta_z = '0;
    in_ch.distance_squared = '0;
    for (int n = 0; n < NUM_SLOTS; n++) begin
      m_epoch_of[n] = 1'b0;
      for (int k = 0; k < 3; k++) m_force[n][k] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_frames();
    test_output_backpressure();
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: lj_pair_force_accumulator_core.f
+incdir+hdl
hdl/ljpfa_pkg.sv
hdl/ljpfa_if.sv
hdl/ljpfa_div.sv
hdl/ljpfa_mul.sv
hdl/ljpfa_dpath.sv
hdl/ljpfa_ctrl.sv
hdl/lj_pair_force_accumulator_core.sv
tb/testbench.sv
